// ----- rtl/core/ltdd_pkg.sv -----
package ltdd_pkg;

  localparam int NUM_RESOURCES_DEF = 4;
  localparam int ENTITIES_DEF      = 8;
  localparam int MASK_W            = 4;
  localparam logic [MASK_W-1:0] MASK_RESET = 4'hF;

  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_SCAN    = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [1:0] resource_id;
    logic [2:0] requester_id;
  } in_item_t;

  typedef struct packed {
    logic       granted;
    logic       now_waiting;
    logic       not_present;
    logic       released;
    logic       deadlock_found;
    logic [2:0] victim_entity;
    logic [1:0] freed_resource;
  } out_item_t;

  // verdict of one hop of the wait-for chain
  typedef struct packed {
    logic stop;       // chain broken: no wait, bad resource or free resource
    logic found;      // holder is the chain's starting requester
    logic exhausted;  // hop limit reached without closing
  } hop_t;

endpackage

// ----- rtl/core/lock_table_deadlock_detector.sv -----
// Lock table with wait-for-graph deadlock detection. Acquire, release and
// the unused code keep busy low and the result strobes on out_valid the
// next cycle, so these can arrive back to back. A deadlock scan holds busy
// high while one hop comparator walks the chains through the single read
// port of the wait table: a start step per starting requester, then per hop
// a registered table read and then a compare, at most ENTITIES hops per start,
// then a sweep over the resources finds the victim's lowest held resource.
// Results are shown for exactly one cycle and cannot be held off; cfg_ready
// is always high and the mask should be written only while the block is idle.
module lock_table_deadlock_detector #(
  parameter int NUM_RESOURCES = ltdd_pkg::NUM_RESOURCES_DEF,
  parameter int ENTITIES      = ltdd_pkg::ENTITIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  ltdd_pkg::in_item_t            in_data,
  output logic                          out_valid,
  output ltdd_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ltdd_pkg::MASK_W-1:0]   cfg_data
);

  localparam int EW = $clog2(ENTITIES);
  localparam int RW = $clog2(NUM_RESOURCES);
  localparam int SW = $clog2(ENTITIES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_HOP   = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [ltdd_pkg::MASK_W-1:0]   mask_r;
  logic [NUM_RESOURCES-1:0]      hold_valid_r, hold_valid_nxt;
  logic [EW-1:0]                 hold_id_r [NUM_RESOURCES];
  logic [EW-1:0]                 hold_id_nxt [NUM_RESOURCES];
  logic [SW-1:0]                 start_r, start_nxt;
  logic [SW-1:0]                 hops_r, hops_nxt;
  logic [EW-1:0]                 cur_r, cur_nxt;
  logic [RW-1:0]                 sweep_r, sweep_nxt;
  logic                          out_valid_r, out_valid_nxt;
  ltdd_pkg::out_item_t           out_r, out_nxt;

  logic          accept;
  logic          item_ok;
  logic [RW-1:0] in_res;
  logic [EW-1:0] in_req;
  logic          present;

  logic          wr_en, wr_set;
  logic [EW-1:0] wr_addr;
  logic [RW-1:0] wr_res;
  logic          rd_valid;
  logic [RW-1:0] rd_res;
  logic          h_valid;
  logic [EW-1:0] h_id;
  logic [EW-1:0] start_id;
  ltdd_pkg::hop_t verdict;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign in_res  = RW'(in_data.resource_id);
  assign in_req  = EW'(in_data.requester_id);
  assign item_ok = (32'(in_data.resource_id) < NUM_RESOURCES) &&
                   (32'(in_data.requester_id) < ENTITIES);
  assign present = mask_r[in_data.resource_id];
  assign start_id = EW'(start_r);

  assign h_valid = hold_valid_r[rd_res];
  assign h_id    = hold_id_r[rd_res];

  ltdd_wait_store #(
    .NUM_RESOURCES(NUM_RESOURCES),
    .ENTITIES     (ENTITIES)
  ) u_wait (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_set  (wr_set),
    .wr_addr (wr_addr),
    .wr_res  (wr_res),
    .rd_addr (cur_r),
    .rd_valid(rd_valid),
    .rd_res  (rd_res)
  );

  ltdd_hop_unit #(
    .NUM_RESOURCES(NUM_RESOURCES),
    .ENTITIES     (ENTITIES)
  ) u_hop (
    .w_valid (rd_valid),
    .w_res   (rd_res),
    .h_valid (h_valid),
    .h_id    (h_id),
    .start_id(start_id),
    .hops    (hops_r),
    .verdict (verdict)
  );

  always_comb begin
    state_nxt      = state_r;
    hold_valid_nxt = hold_valid_r;
    hold_id_nxt    = hold_id_r;
    start_nxt      = start_r;
    hops_nxt       = hops_r;
    cur_nxt        = cur_r;
    sweep_nxt      = sweep_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    wr_en          = 1'b0;
    wr_set         = 1'b0;
    wr_addr        = in_req;
    wr_res         = in_res;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt = '0;
          if (in_data.operation == ltdd_pkg::OP_SCAN) begin
            start_nxt = '0;
            state_nxt = S_START;
          end else begin
            out_valid_nxt = 1'b1;
            if (in_data.operation == ltdd_pkg::OP_ACQUIRE && item_ok) begin
              if (!present) begin
                out_nxt.not_present = 1'b1;
              end else if (!hold_valid_r[in_res]) begin
                hold_valid_nxt[in_res] = 1'b1;
                hold_id_nxt[in_res]    = in_req;
                wr_en                  = 1'b1;
                out_nxt.granted        = 1'b1;
              end else begin
                wr_en               = 1'b1;
                wr_set              = 1'b1;
                out_nxt.now_waiting = 1'b1;
              end
            end else if (in_data.operation == ltdd_pkg::OP_RELEASE && item_ok) begin
              if (hold_valid_r[in_res] && hold_id_r[in_res] == in_req) begin
                hold_valid_nxt[in_res] = 1'b0;
                out_nxt.released       = 1'b1;
              end
            end
          end
        end
      end
      S_START: begin
        if (start_r == SW'(ENTITIES)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cur_nxt   = start_id;
          hops_nxt  = '0;
          state_nxt = S_HOP;
        end
      end
      S_HOP: begin
        // wait table read of cur_r is in flight
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (verdict.found) begin
          sweep_nxt = '0;
          state_nxt = S_SWEEP;
        end else if (verdict.stop || verdict.exhausted) begin
          start_nxt = start_r + SW'(1);
          state_nxt = S_START;
        end else begin
          cur_nxt   = h_id;
          hops_nxt  = hops_r + SW'(1);
          state_nxt = S_HOP;
        end
      end
      S_SWEEP: begin
        // lowest-numbered resource held by the victim
        if (hold_valid_r[sweep_r] && hold_id_r[sweep_r] == start_id) begin
          hold_valid_nxt[sweep_r] = 1'b0;
          wr_en                   = 1'b1;
          wr_addr                 = start_id;
          out_nxt.deadlock_found  = 1'b1;
          out_nxt.victim_entity   = 3'(start_id);
          out_nxt.freed_resource  = 2'(sweep_r);
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end else if (sweep_r == RW'(NUM_RESOURCES - 1)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          sweep_nxt = sweep_r + RW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mask_r       <= ltdd_pkg::MASK_RESET;
      hold_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        mask_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_id_r <= hold_id_nxt;
    start_r   <= start_nxt;
    hops_r    <= hops_nxt;
    cur_r     <= cur_nxt;
    sweep_r   <= sweep_nxt;
    out_r     <= out_nxt;
  end

  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_data.granted, out_data.now_waiting,
      out_data.not_present, out_data.released, out_data.deadlock_found}) <= 1)
    else $error("more than one outcome flag in a result");

  a_eval_after_hop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL |-> $past(state_r == S_HOP))
    else $error("hop evaluated without a wait table read");

  a_sweep_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWEEP |-> $past(state_r == S_SWEEP || state_r == S_EVAL))
    else $error("victim sweep entered without a closed chain");

  a_scan_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.deadlock_found |-> !busy)
    else $error("deadlock result while scan still running");

endmodule

// ----- rtl/core/ltdd_wait_store.sv -----
module ltdd_wait_store #(
  parameter int NUM_RESOURCES = ltdd_pkg::NUM_RESOURCES_DEF,
  parameter int ENTITIES      = ltdd_pkg::ENTITIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic                             wr_set,
  input  logic [$clog2(ENTITIES)-1:0]      wr_addr,
  input  logic [$clog2(NUM_RESOURCES)-1:0] wr_res,
  input  logic [$clog2(ENTITIES)-1:0]      rd_addr,
  output logic                             rd_valid,
  output logic [$clog2(NUM_RESOURCES)-1:0] rd_res
);

  localparam int RW = $clog2(NUM_RESOURCES);

  logic [ENTITIES-1:0] valid_r;
  logic [RW-1:0]       mem [ENTITIES];
  logic                rd_valid_r;
  logic [RW-1:0]       rd_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= wr_set;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_set) begin
      mem[wr_addr] <= wr_res;
    end
    rd_res_r   <= mem[rd_addr];
    rd_valid_r <= valid_r[rd_addr];
  end

  assign rd_valid = rd_valid_r;
  assign rd_res   = rd_res_r;

endmodule

// ----- rtl/core/ltdd_hop_unit.sv -----
module ltdd_hop_unit #(
  parameter int NUM_RESOURCES = ltdd_pkg::NUM_RESOURCES_DEF,
  parameter int ENTITIES      = ltdd_pkg::ENTITIES_DEF
) (
  input  logic                             w_valid,
  input  logic [$clog2(NUM_RESOURCES)-1:0] w_res,
  input  logic                             h_valid,
  input  logic [$clog2(ENTITIES)-1:0]      h_id,
  input  logic [$clog2(ENTITIES)-1:0]      start_id,
  input  logic [$clog2(ENTITIES+1)-1:0]    hops,
  output ltdd_pkg::hop_t                   verdict
);

  localparam int SW = $clog2(ENTITIES + 1);

  logic res_ok;
  logic [SW:0] hops_inc;

  assign res_ok   = ({1'b0, w_res} < (($clog2(NUM_RESOURCES) + 1)'(NUM_RESOURCES)));
  assign hops_inc = {1'b0, hops} + (SW + 1)'(1);

  always_comb begin
    verdict.stop      = !w_valid || !res_ok || !h_valid;
    verdict.found     = !verdict.stop && (h_id == start_id);
    verdict.exhausted = !verdict.stop && !verdict.found &&
                        (hops_inc == (SW + 1)'(ENTITIES));
  end

endmodule
